### hw/rtl/bipt_pkg.sv
// Shared types, constants and helper functions of the block insert point transform.
package bipt_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE_POINT   = 3'd0;
  localparam logic [2:0] REG_INSERT_POINT = 3'd1;
  localparam logic [2:0] REG_SCALE_PAIR   = 3'd2;
  localparam logic [2:0] REG_SPACING_PAIR = 3'd3;
  localparam logic [2:0] REG_ROTATION     = 3'd4;
  localparam logic [2:0] REG_COLUMN_COUNT = 3'd5;
  localparam logic [2:0] REG_ROW_COUNT    = 3'd6;

  localparam logic [63:0] SCALE_RESET = 64'h0001_0000_0001_0000;

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [31:0] THETA_STEP = 32'd292818;
  localparam logic [37:0] SCALED_LIM = '1;

  typedef struct packed {
    logic [63:0] base_point;
    logic [63:0] insert_point;
    logic [63:0] scale_pair;
    logic [63:0] spacing_pair;
    logic [15:0] rotation;
    logic [3:0]  column_count;
    logic [3:0]  row_count;
  } cfg_t;

  // One rotated point waiting for the array expansion.
  typedef struct packed {
    logic signed [40:0] rx;
    logic signed [40:0] ry;
    logic signed [31:0] olen;
  } entry_t;

  // Horner divisors: sine terms first, then cosine terms.
  function automatic logic [6:0] horner_div(input logic [3:0] idx);
    logic [6:0] d;
    case (idx)
      4'd0:    d = 7'd72;
      4'd1:    d = 7'd42;
      4'd2:    d = 7'd20;
      4'd3:    d = 7'd6;
      4'd4:    d = 7'd90;
      4'd5:    d = 7'd56;
      4'd6:    d = 7'd30;
      4'd7:    d = 7'd12;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) for the same order of terms.
  function automatic logic [31:0] horner_recip(input logic [3:0] idx);
    logic [31:0] r;
    case (idx)
      4'd0:    r = 32'd59652323;
      4'd1:    r = 32'd102261126;
      4'd2:    r = 32'd214748364;
      4'd3:    r = 32'd715827882;
      4'd4:    r = 32'd47721858;
      4'd5:    r = 32'd76695844;
      4'd6:    r = 32'd143165576;
      4'd7:    r = 32'd357913941;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] s;
    if (v > 48'sd2147483647) begin
      s = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      s = 32'sh8000_0000;
    end else begin
      s = v[31:0];
    end
    return s;
  endfunction

endpackage

### hw/rtl/bipt_front.sv
// Front end: accepts a point, works out sine and cosine, scaling and rotation on one multiplier.
module bipt_front import bipt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic [30:0]        in_length,
  output logic               q_we,
  output entry_t             q_wdata,
  input  logic               q_full
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_TH   = 5'd1;
  localparam logic [4:0] ST_SQ   = 5'd2;
  localparam logic [4:0] ST_X2   = 5'd3;
  localparam logic [4:0] ST_H1   = 5'd4;
  localparam logic [4:0] ST_H2   = 5'd5;
  localparam logic [4:0] ST_H3   = 5'd6;
  localparam logic [4:0] ST_SIN  = 5'd7;
  localparam logic [4:0] ST_SINF = 5'd8;
  localparam logic [4:0] ST_COS  = 5'd9;
  localparam logic [4:0] ST_EX   = 5'd10;
  localparam logic [4:0] ST_EY   = 5'd11;
  localparam logic [4:0] ST_LEN  = 5'd12;
  localparam logic [4:0] ST_ROT  = 5'd13;
  localparam logic [4:0] ST_RM   = 5'd14;
  localparam logic [4:0] ST_RA   = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  localparam logic [3:0] LAST_SIN_TERM = 4'd3;
  localparam logic [3:0] LAST_COS_TERM = 4'd8;
  localparam logic [3:0] FIRST_COS_TERM = 4'd4;

  logic [4:0]  state_r, state_nxt;
  logic [3:0]  hidx_r;
  logic [2:0]  pidx_r;
  logic [11:0] t_r;
  logic [1:0]  quad_r;
  logic        swap_r;
  logic        dx_neg_r, dy_neg_r;
  logic [31:0] dx_mag_r, dy_mag_r;
  logic [30:0] len_r;
  logic [29:0] th_r, x2_r, v_r;
  logic [30:0] u_r;
  logic [24:0] s_raw_r, s_mag_r, c_mag_r;
  logic        s_neg_r, c_neg_r;
  logic        ex_neg_r, ey_neg_r;
  logic [37:0] ex_mag_r, ey_mag_r;
  logic signed [31:0] olen_r;
  logic signed [63:0] accx_r, accy_r;
  logic [63:0] prod_r;

  // Angle reduction into quadrant and first-octant angle.
  logic [16:0] a0, a1, a2;
  logic [12:0] rr;
  logic [1:0]  quad;
  logic [11:0] tt;
  logic        swp;

  always_comb begin
    a0 = 17'($signed({{2{cfg.rotation[15]}}, cfg.rotation}) + 18'sd46080);
    a1 = (a0 >= 17'd46080) ? a0 - 17'd46080 : a0;
    a2 = (a1 >= 17'd23040) ? a1 - 17'd23040 : a1;
    if (a2 >= 17'd17280) begin
      quad = 2'd3;
      rr   = 13'(a2 - 17'd17280);
    end else if (a2 >= 17'd11520) begin
      quad = 2'd2;
      rr   = 13'(a2 - 17'd11520);
    end else if (a2 >= 17'd5760) begin
      quad = 2'd1;
      rr   = 13'(a2 - 17'd5760);
    end else begin
      quad = 2'd0;
      rr   = 13'(a2);
    end
    swp = (rr > 13'd2880);
    tt  = swp ? 12'(13'd5760 - rr) : 12'(rr);
  end

  logic [32:0] dx, dy;
  logic [31:0] sx_raw, sy_raw, sx_mag, sy_mag;
  logic        sx_neg, sy_neg;

  always_comb begin
    dx = {in_point_x[31], in_point_x} - {cfg.base_point[31], cfg.base_point[31:0]};
    dy = {in_point_y[31], in_point_y} - {cfg.base_point[63], cfg.base_point[63:32]};
    sx_raw = cfg.scale_pair[31:0];
    sy_raw = cfg.scale_pair[63:32];
    sx_neg = sx_raw[31];
    sy_neg = sy_raw[31];
    sx_mag = sx_neg ? 32'd0 - sx_raw : sx_raw;
    sy_mag = sy_neg ? 32'd0 - sy_raw : sy_raw;
  end

  // Horner correction: the reciprocal estimate is at most one below the quotient.
  logic [29:0] q0, qq;
  logic [6:0]  hdiv;
  logic [36:0] qd, rem;

  always_comb begin
    q0   = prod_r[61:32];
    hdiv = horner_div(hidx_r);
    qd   = 37'(q0) * 37'(hdiv);
    rem  = 37'(v_r) - qd;
    qq   = q0 + 30'(rem >= 37'(hdiv));
  end

  // Scaling result: rounded magnitude, clamped.
  logic [63:0] rsum;
  logic [47:0] sq;
  logic [37:0] emag;
  logic [47:0] olen_s;

  always_comb begin
    rsum   = prod_r + 64'd32768;
    sq     = rsum[63:16];
    emag   = (sq > 48'(SCALED_LIM)) ? SCALED_LIM : sq[37:0];
    olen_s = sx_neg ? 48'd0 - sq : sq;
  end

  // Sine and cosine after octant swap and quadrant mapping.
  logic [24:0] c_raw, sw_s, sw_c;
  logic [31:0] c_sum;

  always_comb begin
    c_sum = 32'(u_r) + 32'd32;
    c_raw = c_sum[30:6];
    sw_s  = swap_r ? c_raw : s_raw_r;
    sw_c  = swap_r ? s_raw_r : c_raw;
  end

  // Rotation partial products: each 38-bit offset is split into a low word and a high part.
  logic        use_ey, use_s, part_hi, part_sub, to_y, part_neg;
  logic [37:0] e_mag;
  logic        e_neg;
  logic [24:0] coef_mag;
  logic        coef_neg;
  logic [63:0] part, term;

  always_comb begin
    use_ey   = pidx_r[1];
    use_s    = pidx_r[2] ^ pidx_r[1];
    part_hi  = pidx_r[0];
    part_sub = (pidx_r[2:1] == 2'b01);
    to_y     = pidx_r[2];
    e_mag    = use_ey ? ey_mag_r : ex_mag_r;
    e_neg    = use_ey ? ey_neg_r : ex_neg_r;
    coef_mag = use_s ? s_mag_r : c_mag_r;
    coef_neg = use_s ? s_neg_r : c_neg_r;
    part_neg = e_neg ^ coef_neg ^ part_sub;
    part     = part_hi ? {prod_r[31:0], 32'd0} : prod_r;
    term     = part_neg ? 64'd0 - part : part;
  end

  // Shared multiplier operands.
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_TH: begin
        mul_a = 33'(t_r);
        mul_b = THETA_STEP;
      end
      ST_SQ: begin
        mul_a = 33'(prod_r[29:0]);
        mul_b = 32'(prod_r[29:0]);
      end
      ST_H1: begin
        mul_a = 33'(x2_r);
        mul_b = 32'(u_r);
      end
      ST_H2: begin
        mul_a = 33'(prod_r[59:30]);
        mul_b = horner_recip(hidx_r);
      end
      ST_SIN: begin
        mul_a = 33'(th_r);
        mul_b = 32'(u_r);
      end
      ST_EX: begin
        mul_a = 33'(sx_mag);
        mul_b = dx_mag_r;
      end
      ST_EY: begin
        mul_a = 33'(sy_mag);
        mul_b = dy_mag_r;
      end
      ST_LEN: begin
        mul_a = 33'(sx_mag);
        mul_b = 32'(len_r);
      end
      ST_RM: begin
        mul_a = 33'(coef_mag);
        mul_b = part_hi ? 32'(e_mag[37:32]) : e_mag[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 65'(mul_a) * 65'(mul_b);
  end

  function automatic logic signed [40:0] round24(input logic signed [63:0] acc);
    logic [63:0] m, s;
    logic [40:0] q;
    m = acc[63] ? 64'd0 - acc : acc;
    s = m + 64'd8388608;
    q = {1'b0, s[63:24]};
    return acc[63] ? 41'sd0 - $signed(q) : $signed(q);
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_push) state_nxt = ST_TH;
      ST_TH:   state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_X2;
      ST_X2:   state_nxt = ST_H1;
      ST_H1:   state_nxt = ST_H2;
      ST_H2:   state_nxt = ST_H3;
      ST_H3: begin
        if (hidx_r == LAST_SIN_TERM) state_nxt = ST_SIN;
        else if (hidx_r == LAST_COS_TERM) state_nxt = ST_COS;
        else state_nxt = ST_H1;
      end
      ST_SIN:  state_nxt = ST_SINF;
      ST_SINF: state_nxt = ST_H1;
      ST_COS:  state_nxt = ST_EX;
      ST_EX:   state_nxt = ST_EY;
      ST_EY:   state_nxt = ST_LEN;
      ST_LEN:  state_nxt = ST_ROT;
      ST_ROT:  state_nxt = ST_RM;
      ST_RM:   state_nxt = ST_RA;
      ST_RA:   state_nxt = (pidx_r == 3'd7) ? ST_OUT : ST_RM;
      ST_OUT:  if (!q_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p[63:0];
    case (state_r)
      ST_IDLE: begin
        t_r      <= tt;
        quad_r   <= quad;
        swap_r   <= swp;
        dx_neg_r <= dx[32];
        dy_neg_r <= dy[32];
        dx_mag_r <= dx[32] ? 32'(33'd0 - dx) : dx[31:0];
        dy_mag_r <= dy[32] ? 32'(33'd0 - dy) : dy[31:0];
        len_r    <= in_length;
      end
      ST_SQ: th_r <= prod_r[29:0];
      ST_X2: begin
        x2_r   <= 30'((prod_r + 64'h2000_0000) >> 30);
        u_r    <= Q30_ONE;
        hidx_r <= '0;
      end
      ST_H2: v_r <= prod_r[59:30];
      ST_H3: begin
        u_r <= Q30_ONE - 31'(qq);
        if (hidx_r != LAST_SIN_TERM) hidx_r <= hidx_r + 4'd1;
      end
      ST_SINF: begin
        s_raw_r <= 25'((31'(prod_r[59:30]) + 31'd32) >> 6);
        u_r     <= Q30_ONE;
        hidx_r  <= FIRST_COS_TERM;
      end
      ST_COS: begin
        case (quad_r)
          2'd1: begin
            s_mag_r <= sw_c; s_neg_r <= 1'b0;
            c_mag_r <= sw_s; c_neg_r <= 1'b1;
          end
          2'd2: begin
            s_mag_r <= sw_s; s_neg_r <= 1'b1;
            c_mag_r <= sw_c; c_neg_r <= 1'b1;
          end
          2'd3: begin
            s_mag_r <= sw_c; s_neg_r <= 1'b1;
            c_mag_r <= sw_s; c_neg_r <= 1'b0;
          end
          default: begin
            s_mag_r <= sw_s; s_neg_r <= 1'b0;
            c_mag_r <= sw_c; c_neg_r <= 1'b0;
          end
        endcase
      end
      ST_EY: begin
        ex_mag_r <= emag;
        ex_neg_r <= dx_neg_r ^ sx_neg;
      end
      ST_LEN: begin
        ey_mag_r <= emag;
        ey_neg_r <= dy_neg_r ^ sy_neg;
      end
      ST_ROT: begin
        olen_r <= sat32($signed(olen_s));
        pidx_r <= '0;
        accx_r <= '0;
        accy_r <= '0;
      end
      ST_RA: begin
        if (to_y) accy_r <= accy_r + $signed(term);
        else accx_r <= accx_r + $signed(term);
        pidx_r <= pidx_r + 3'd1;
      end
      default: ;
    endcase
  end

  assign in_full      = (state_r != ST_IDLE);
  assign q_we         = (state_r == ST_OUT) && !q_full;
  assign q_wdata.rx   = round24(accx_r);
  assign q_wdata.ry   = round24(accy_r);
  assign q_wdata.olen = olen_r;

endmodule

### hw/rtl/bipt_queue.sv
// Two-entry queue of rotated points between the front end and the array expansion.
module bipt_queue import bipt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   we,
  input  entry_t wdata,
  output logic   full,
  input  logic   re,
  output entry_t rdata,
  output logic   empty
);

  entry_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (we) wr_ptr_r <= ~wr_ptr_r;
      if (re) rd_ptr_r <= ~rd_ptr_r;
      if (we && !re) count_r <= count_r + 2'd1;
      else if (re && !we) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem_r[wr_ptr_r] <= wdata;
  end

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

endmodule

### hw/rtl/bipt_back.sv
// Back end: walks the insert array, adds offsets, saturates and holds the result register.
module bipt_back import bipt_pkg::*; #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_ROWS    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  entry_t             q_rdata,
  input  logic               q_empty,
  output logic               q_re,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_length,
  output logic [2:0]         out_col_index,
  output logic [2:0]         out_row_index,
  output logic               out_last_instance
);

  logic [3:0] ncols, nrows;
  logic [2:0] col_last, row_last;

  always_comb begin
    if (cfg.column_count == 4'd0) ncols = 4'd1;
    else if (cfg.column_count > 4'(MAX_COLUMNS)) ncols = 4'(MAX_COLUMNS);
    else ncols = cfg.column_count;
    if (cfg.row_count == 4'd0) nrows = 4'd1;
    else if (cfg.row_count > 4'(MAX_ROWS)) nrows = 4'(MAX_ROWS);
    else nrows = cfg.row_count;
    col_last = 3'(ncols - 4'd1);
    row_last = 3'(nrows - 4'd1);
  end

  logic               busy_r;
  entry_t             ent_r;
  logic [2:0]         k_r, r_r;
  logic signed [34:0] coff_r, roff_r;
  logic               ov_r;
  logic signed [31:0] ox_r, oy_r, ol_r;
  logic [2:0]         oc_r, orow_r;
  logic               olast_r;

  logic               advance, col_end, row_end;
  logic signed [47:0] sumx, sumy;

  always_comb begin
    advance = busy_r && (!ov_r || out_pop);
    col_end = (k_r == col_last);
    row_end = (r_r == row_last);
    sumx = 48'(ent_r.rx) + 48'($signed(cfg.insert_point[31:0])) + 48'(coff_r);
    sumy = 48'(ent_r.ry) + 48'($signed(cfg.insert_point[63:32])) + 48'(roff_r);
  end

  assign q_re = !busy_r && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (q_re) busy_r <= 1'b1;
      else if (advance && col_end && row_end) busy_r <= 1'b0;
      if (advance) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_re) begin
      ent_r  <= q_rdata;
      k_r    <= '0;
      r_r    <= '0;
      coff_r <= '0;
      roff_r <= '0;
    end else if (advance) begin
      if (col_end) begin
        k_r    <= '0;
        coff_r <= '0;
        r_r    <= r_r + 3'd1;
        roff_r <= roff_r + 35'($signed(cfg.spacing_pair[63:32]));
      end else begin
        k_r    <= k_r + 3'd1;
        coff_r <= coff_r + 35'($signed(cfg.spacing_pair[31:0]));
      end
    end
    if (advance) begin
      ox_r    <= sat32(sumx);
      oy_r    <= sat32(sumy);
      ol_r    <= ent_r.olen;
      oc_r    <= k_r;
      orow_r  <= r_r;
      olast_r <= col_end && row_end;
    end
  end

  assign out_empty         = !ov_r;
  assign out_x             = ox_r;
  assign out_y             = oy_r;
  assign out_length        = ol_r;
  assign out_col_index     = oc_r;
  assign out_row_index     = orow_r;
  assign out_last_instance = olast_r;

endmodule

### hw/rtl/block_insert_point_transform.sv
// Top level of the block insert point transform: configuration registers and the two halves.
// Each request (a point and a length) is scaled about the base point, rotated by the insert
// angle and placed once for every column and row of the insert array, row by row, one result
// per cycle while out_pop drains the output; the last result of a request carries
// out_last_instance. The front end evaluates sine and cosine by Horner's method and forms the
// split rotation products on its single shared multiplier, and it takes no new request until
// its result is written to the queue; a two-entry queue lets the front start the next request
// while the array of the previous one is still being emitted.
// Configuration may only be written while no request is in flight.
module block_insert_point_transform import bipt_pkg::*; #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_ROWS    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic [30:0]        in_length,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_length,
  output logic [2:0]         out_col_index,
  output logic [2:0]         out_row_index,
  output logic               out_last_instance
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_point   <= '0;
      cfg_r.insert_point <= '0;
      cfg_r.scale_pair   <= SCALE_RESET;
      cfg_r.spacing_pair <= '0;
      cfg_r.rotation     <= '0;
      cfg_r.column_count <= 4'd1;
      cfg_r.row_count    <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_POINT:   cfg_r.base_point   <= cfg_data;
        REG_INSERT_POINT: cfg_r.insert_point <= cfg_data;
        REG_SCALE_PAIR:   cfg_r.scale_pair   <= cfg_data;
        REG_SPACING_PAIR: cfg_r.spacing_pair <= cfg_data;
        REG_ROTATION:     cfg_r.rotation     <= cfg_data[15:0];
        REG_COLUMN_COUNT: cfg_r.column_count <= cfg_data[3:0];
        REG_ROW_COUNT:    cfg_r.row_count    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic   q_we, q_full, q_re, q_empty;
  entry_t q_wdata, q_rdata;

  bipt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_length  (in_length),
    .q_we       (q_we),
    .q_wdata    (q_wdata),
    .q_full     (q_full)
  );

  bipt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (q_we),
    .wdata (q_wdata),
    .full  (q_full),
    .re    (q_re),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  bipt_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_rdata           (q_rdata),
    .q_empty           (q_empty),
    .q_re              (q_re),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_length        (out_length),
    .out_col_index     (out_col_index),
    .out_row_index     (out_row_index),
    .out_last_instance (out_last_instance)
  );

endmodule
